@@ rtl/ncid_pkg.sv @@
// ----------------------------------------------------------------------------
// ncid_pkg
// Shared types and constants for the connection id frame parser: parse
// phases, result kinds, status codes and field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package ncid_pkg;

    localparam int NCID_MAX_ID_BYTES = 20;
    localparam int NCID_TOKEN_BYTES  = 16;

    localparam int BYTE_W     = 8;
    localparam int KIND_W     = 3;
    localparam int VALUE_W    = 62;
    localparam int IDX_W      = 5;
    localparam int STATUS_W   = 2;
    localparam int CONSUMED_W = 6;
    localparam int VLEFT_W    = 3;
    localparam int PAYLOAD_W  = 6;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SEQ,
        PH_RPT,
        PH_LEN,
        PH_ID,
        PH_TOKEN
    } t_phase;

    typedef logic [KIND_W-1:0]   t_kind;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_kind KIND_SEQ   = 3'd0;
    localparam t_kind KIND_RPT   = 3'd1;
    localparam t_kind KIND_LEN   = 3'd2;
    localparam t_kind KIND_ID    = 3'd3;
    localparam t_kind KIND_TOKEN = 3'd4;
    localparam t_kind KIND_NONE  = 3'd5;

    localparam t_status ST_BUSY  = 2'd0;
    localparam t_status ST_DONE  = 2'd1;
    localparam t_status ST_TRUNC = 2'd2;
    localparam t_status ST_LONG  = 2'd3;

    localparam logic [1:0] VI_LEN1 = 2'd0;
    localparam logic [1:0] VI_LEN2 = 2'd1;
    localparam logic [1:0] VI_LEN4 = 2'd2;
    localparam logic [1:0] VI_LEN8 = 2'd3;

endpackage

`default_nettype wire

@@ rtl/new_connection_id_frame_parser_core.sv @@
// ----------------------------------------------------------------------------
// new_connection_id_frame_parser_core
// Byte-serial parser for connection id frames: varint sequence and
// retire-prior-to fields, id length, id bytes and the reset token.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one frame byte per request,
//   with i_frame_start on the type byte and i_buffer_end on the last byte
//   available. Output channel (o_out_valid / i_out_ready) gives zero or one
//   result per input byte: each parsed field, a done result on the last
//   token byte with the consumed byte count, or an error result (truncated
//   buffer or id too long), after which earlier fields are to be discarded.
//   Each result appears in the cycle after its byte is taken. Throughput
//   is one byte per cycle while results are taken; a varint shift, two
//   counts and three compares lie between the state and result registers.
//   A stalled receiver holds the result register and drops o_in_ready until
//   it is taken; o_in_ready stays high in a cycle where the result is taken.
//   Reset puts the parser idle; bytes are ignored until a frame start.
// ----------------------------------------------------------------------------
`default_nettype none

module new_connection_id_frame_parser_core #(
    parameter int MAX_ID_BYTES = ncid_pkg::NCID_MAX_ID_BYTES,
    parameter int TOKEN_BYTES  = ncid_pkg::NCID_TOKEN_BYTES
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [ncid_pkg::BYTE_W-1:0]       i_data_byte,
    input  wire logic                              i_frame_start,
    input  wire logic                              i_buffer_end,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic [ncid_pkg::KIND_W-1:0]            o_field_kind,
    output logic [ncid_pkg::VALUE_W-1:0]           o_field_value,
    output logic [ncid_pkg::IDX_W-1:0]             o_byte_index,
    output logic [ncid_pkg::STATUS_W-1:0]          o_parse_status,
    output logic [ncid_pkg::CONSUMED_W-1:0]        o_bytes_consumed
);
    import ncid_pkg::*;

    localparam int CNT_MAX = (MAX_ID_BYTES > TOKEN_BYTES) ? MAX_ID_BYTES : TOKEN_BYTES;
    localparam int CNT_W   = $clog2(CNT_MAX + 1);
    localparam int IDL_W   = $clog2(MAX_ID_BYTES + 1);

    // parse state
    t_phase                  r_phase, n_phase;
    logic [VLEFT_W-1:0]      r_vleft, n_vleft;
    logic [VALUE_W-1:0]      r_acc, n_acc;
    logic [IDL_W-1:0]        r_idlen, n_idlen;
    logic [CNT_W-1:0]        r_fbc, n_fbc;
    logic [CONSUMED_W-1:0]   r_consumed, n_consumed;

    // result register
    logic                    r_out_valid;
    t_kind                   r_kind;
    logic [VALUE_W-1:0]      r_value;
    logic [IDX_W-1:0]        r_idx;
    t_status                 r_status;
    logic [CONSUMED_W-1:0]   r_cons;

    logic                    w_accept;
    logic [VLEFT_W-1:0]      w_vleft_first;
    logic [VLEFT_W-1:0]      w_vleft_nx;
    logic [VALUE_W-1:0]      w_acc_nx;
    logic [CNT_W-1:0]        w_fbc_inc;
    logic [CONSUMED_W-1:0]   w_consumed_inc;
    logic                    w_id_last;
    logic                    w_token_last;
    logic                    w_len_long;

    logic                    w_res_valid;
    t_kind                   w_kind;
    logic [VALUE_W-1:0]      w_value;
    logic [IDX_W-1:0]        w_idx;
    t_status                 w_status;
    logic [CONSUMED_W-1:0]   w_cons;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    // varint and counter datapath
    always_comb begin
        unique case (i_data_byte[7:6])
            VI_LEN1: w_vleft_first = VLEFT_W'(0);
            VI_LEN2: w_vleft_first = VLEFT_W'(1);
            VI_LEN4: w_vleft_first = VLEFT_W'(3);
            VI_LEN8: w_vleft_first = VLEFT_W'(7);
            default: w_vleft_first = VLEFT_W'(0);
        endcase
        if (r_vleft == '0) begin
            w_vleft_nx = w_vleft_first;
            w_acc_nx   = VALUE_W'(i_data_byte[PAYLOAD_W-1:0]);
        end else begin
            w_vleft_nx = r_vleft - VLEFT_W'(1);
            w_acc_nx   = {r_acc[VALUE_W-BYTE_W-1:0], i_data_byte};
        end
        w_fbc_inc      = r_fbc + CNT_W'(1);
        w_consumed_inc = r_consumed + CONSUMED_W'(1);
        w_id_last      = w_fbc_inc >= CNT_W'(r_idlen);
        w_token_last   = w_fbc_inc >= CNT_W'(TOKEN_BYTES);
        w_len_long     = i_data_byte > BYTE_W'(MAX_ID_BYTES);
    end

    // next state
    always_comb begin
        n_phase    = r_phase;
        n_vleft    = r_vleft;
        n_acc      = r_acc;
        n_idlen    = r_idlen;
        n_fbc      = r_fbc;
        n_consumed = r_consumed;
        if (w_accept) begin
            if (i_frame_start) begin
                n_phase    = i_buffer_end ? PH_IDLE : PH_SEQ;
                n_vleft    = '0;
                n_acc      = '0;
                n_idlen    = '0;
                n_fbc      = '0;
                n_consumed = CONSUMED_W'(1);
            end else if (r_phase != PH_IDLE) begin
                n_consumed = w_consumed_inc;
                unique case (r_phase)
                    PH_SEQ, PH_RPT: begin
                        n_vleft = w_vleft_nx;
                        n_acc   = w_acc_nx;
                        if (i_buffer_end) begin
                            n_phase = PH_IDLE;
                        end else if (w_vleft_nx == '0) begin
                            n_phase = (r_phase == PH_SEQ) ? PH_RPT : PH_LEN;
                        end
                    end
                    PH_LEN: begin
                        if (w_len_long || i_buffer_end) begin
                            n_phase = PH_IDLE;
                        end else begin
                            n_idlen = IDL_W'(i_data_byte);
                            n_fbc   = '0;
                            n_phase = (i_data_byte == '0) ? PH_TOKEN : PH_ID;
                        end
                    end
                    PH_ID: begin
                        if (i_buffer_end) begin
                            n_phase = PH_IDLE;
                        end else if (w_id_last) begin
                            n_fbc   = '0;
                            n_phase = PH_TOKEN;
                        end else begin
                            n_fbc = w_fbc_inc;
                        end
                    end
                    PH_TOKEN: begin
                        if (w_token_last) begin
                            n_fbc   = '0;
                            n_phase = PH_IDLE;
                        end else begin
                            n_fbc = w_fbc_inc;
                            if (i_buffer_end) begin
                                n_phase = PH_IDLE;
                            end
                        end
                    end
                    default: n_phase = PH_IDLE;
                endcase
            end
        end
    end

    // result
    always_comb begin
        w_res_valid = 1'b0;
        w_kind      = KIND_NONE;
        w_value     = '0;
        w_idx       = '0;
        w_status    = ST_BUSY;
        w_cons      = '0;
        if (w_accept) begin
            if (i_frame_start) begin
                if (i_buffer_end) begin
                    w_res_valid = 1'b1;
                    w_status    = ST_TRUNC;
                end
            end else begin
                unique case (r_phase)
                    PH_SEQ, PH_RPT: begin
                        if (i_buffer_end) begin
                            w_res_valid = 1'b1;
                            w_status    = ST_TRUNC;
                        end else if (w_vleft_nx == '0) begin
                            w_res_valid = 1'b1;
                            w_kind      = (r_phase == PH_SEQ) ? KIND_SEQ : KIND_RPT;
                            w_value     = w_acc_nx;
                        end
                    end
                    PH_LEN: begin
                        w_res_valid = 1'b1;
                        if (w_len_long) begin
                            w_status = ST_LONG;
                        end else if (i_buffer_end) begin
                            w_status = ST_TRUNC;
                        end else begin
                            w_kind  = KIND_LEN;
                            w_value = VALUE_W'(i_data_byte);
                        end
                    end
                    PH_ID: begin
                        w_res_valid = 1'b1;
                        if (i_buffer_end) begin
                            w_status = ST_TRUNC;
                        end else begin
                            w_kind  = KIND_ID;
                            w_value = VALUE_W'(i_data_byte);
                            w_idx   = IDX_W'(r_fbc);
                        end
                    end
                    PH_TOKEN: begin
                        w_res_valid = 1'b1;
                        if (w_token_last) begin
                            w_kind   = KIND_TOKEN;
                            w_value  = VALUE_W'(i_data_byte);
                            w_idx    = IDX_W'(r_fbc);
                            w_status = ST_DONE;
                            w_cons   = w_consumed_inc;
                        end else if (i_buffer_end) begin
                            w_status = ST_TRUNC;
                        end else begin
                            w_kind  = KIND_TOKEN;
                            w_value = VALUE_W'(i_data_byte);
                            w_idx   = IDX_W'(r_fbc);
                        end
                    end
                    default: w_res_valid = 1'b0;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_vleft    <= '0;
            r_acc      <= '0;
            r_idlen    <= '0;
            r_fbc      <= '0;
            r_consumed <= '0;
        end else begin
            r_phase    <= n_phase;
            r_vleft    <= n_vleft;
            r_acc      <= n_acc;
            r_idlen    <= n_idlen;
            r_fbc      <= n_fbc;
            r_consumed <= n_consumed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            r_kind   <= w_kind;
            r_value  <= w_value;
            r_idx    <= w_idx;
            r_status <= w_status;
            r_cons   <= w_cons;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_field_kind     = r_kind;
    assign o_field_value    = r_value;
    assign o_byte_index     = r_idx;
    assign o_parse_status   = r_status;
    assign o_bytes_consumed = r_cons;

    a_done_is_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_parse_status == ST_DONE)) |-> (o_field_kind == KIND_TOKEN))
        else $error("done result without token kind");

    a_error_kind_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && ((o_parse_status == ST_TRUNC) || (o_parse_status == ST_LONG)))
        |-> ((o_field_kind == KIND_NONE) && (o_field_value == '0)))
        else $error("error result carries a field");

    a_final_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_valid && (w_status != ST_BUSY)) |=> (r_phase == PH_IDLE))
        else $error("parser not idle after done or error");

    a_id_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_ID) |-> ((r_idlen != '0) && (CNT_W'(r_idlen) > r_fbc)))
        else $error("id byte count out of range");

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the connection id frame parser. A queue of frame
// bytes (directed corner cases, then random frames that are mostly well
// formed, with truncated, restarted and overlong-id frames and idle noise
// mixed in) feeds a valid/ready driver. Each accepted request runs through
// a byte-level parser model whose expected fields are checked in order
// against every result taken from the output channel.
// ----------------------------------------------------------------------------
module testbench;
    import ncid_pkg::*;

    localparam int RANDOM_BYTES = 1800;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              start;
        logic              last;
    } t_frame_byte;

    typedef struct packed {
        logic [KIND_W-1:0]     kind;
        logic [VALUE_W-1:0]    value;
        logic [IDX_W-1:0]      idx;
        logic [STATUS_W-1:0]   status;
        logic [CONSUMED_W-1:0] consumed;
    } t_field_result;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic out_ready = 1'b0;
    t_frame_byte cur_byte = '0;

    logic                  o_in_ready;
    logic                  o_out_valid;
    logic [KIND_W-1:0]     o_field_kind;
    logic [VALUE_W-1:0]    o_field_value;
    logic [IDX_W-1:0]      o_byte_index;
    logic [STATUS_W-1:0]   o_parse_status;
    logic [CONSUMED_W-1:0] o_bytes_consumed;

    t_frame_byte   frame_bytes[$];
    t_field_result expected_fields[$];

    // parser model state
    t_phase                ph = PH_IDLE;
    logic [3:0]            vleft = '0;
    logic [VALUE_W-1:0]    acc = '0;
    logic [IDX_W-1:0]      id_len = '0;
    logic [IDX_W-1:0]      fcnt = '0;
    logic [CONSUMED_W-1:0] cons = '0;

    int n_total = 0;
    int n_frames = 0;
    int n_frame_reqs = 0;
    int n_accepted = 0;
    int n_checked = 0;
    int n_done = 0;
    int n_trunc = 0;
    int n_long = 0;
    int n_in_stalls = 0;
    int n_errors = 0;
    int n_cycles = 0;
    int hold_left = 0;
    logic hold_used = 1'b0;
    int tx_idle_pct;
    int rx_idle_pct;

    new_connection_id_frame_parser_core uut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (o_in_ready),
        .i_data_byte      (cur_byte.data),
        .i_frame_start    (cur_byte.start),
        .i_buffer_end     (cur_byte.last),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (out_ready),
        .o_field_kind     (o_field_kind),
        .o_field_value    (o_field_value),
        .o_byte_index     (o_byte_index),
        .o_parse_status   (o_parse_status),
        .o_bytes_consumed (o_bytes_consumed)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    always_comb begin
        if (n_accepted < n_total / 3) begin
            tx_idle_pct = 23;
            rx_idle_pct = 69;
        end else if (n_accepted < 2 * n_total / 3) begin
            tx_idle_pct = 69;
            rx_idle_pct = 23;
        end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        n_errors++;
        $display("mismatch: %s got %0h want %0h (result %0d)", what, got, want,
                 n_checked);
    endtask

    function automatic t_field_result error_result(input logic [STATUS_W-1:0] status);
        t_field_result r;
        r = '0;
        r.kind = KIND_NONE;
        r.status = status;
        return r;
    endfunction

    // byte-level frame parser, pushes the field this request completes
    task automatic parse_frame_byte(input t_frame_byte fb);
        t_field_result r;
        logic emit;
        logic [IDX_W-1:0] pos;
        r = '0;
        emit = 1'b0;
        if (fb.start) begin
            ph = PH_SEQ;
            vleft = '0;
            acc = '0;
            id_len = '0;
            fcnt = '0;
            cons = CONSUMED_W'(1);
            if (fb.last) begin
                ph = PH_IDLE;
                r = error_result(ST_TRUNC);
                emit = 1'b1;
            end
        end else if (ph != PH_IDLE) begin
            cons = cons + 1'b1;
            case (ph)
                PH_SEQ, PH_RPT: begin
                    if (vleft == 0) begin
                        vleft = (4'd1 << fb.data[7:6]) - 4'd1;
                        acc = {56'd0, fb.data[5:0]};
                    end else begin
                        acc = {acc[VALUE_W-9:0], fb.data};
                        vleft = vleft - 1'b1;
                    end
                    if (fb.last) begin
                        ph = PH_IDLE;
                        r = error_result(ST_TRUNC);
                        emit = 1'b1;
                    end else if (vleft == 0) begin
                        r.kind = (ph == PH_SEQ) ? KIND_SEQ : KIND_RPT;
                        r.value = acc;
                        r.status = ST_BUSY;
                        emit = 1'b1;
                        ph = (ph == PH_SEQ) ? PH_RPT : PH_LEN;
                    end
                end
                PH_LEN: begin
                    emit = 1'b1;
                    if (fb.data > NCID_MAX_ID_BYTES) begin
                        ph = PH_IDLE;
                        r = error_result(ST_LONG);
                    end else if (fb.last) begin
                        ph = PH_IDLE;
                        r = error_result(ST_TRUNC);
                    end else begin
                        id_len = fb.data[IDX_W-1:0];
                        fcnt = '0;
                        ph = (fb.data == 0) ? PH_TOKEN : PH_ID;
                        r.kind = KIND_LEN;
                        r.value = VALUE_W'(fb.data);
                        r.status = ST_BUSY;
                    end
                end
                PH_ID: begin
                    pos = fcnt;
                    emit = 1'b1;
                    if (fb.last) begin
                        ph = PH_IDLE;
                        r = error_result(ST_TRUNC);
                    end else begin
                        fcnt = fcnt + 1'b1;
                        if (fcnt >= id_len) begin
                            fcnt = '0;
                            ph = PH_TOKEN;
                        end
                        r.kind = KIND_ID;
                        r.value = VALUE_W'(fb.data);
                        r.idx = pos;
                        r.status = ST_BUSY;
                    end
                end
                default: begin
                    pos = fcnt;
                    fcnt = fcnt + 1'b1;
                    emit = 1'b1;
                    r.kind = KIND_TOKEN;
                    r.value = VALUE_W'(fb.data);
                    r.idx = pos;
                    r.status = ST_BUSY;
                    if (fcnt >= NCID_TOKEN_BYTES) begin
                        fcnt = '0;
                        ph = PH_IDLE;
                        r.status = ST_DONE;
                        r.consumed = cons;
                    end else if (fb.last) begin
                        ph = PH_IDLE;
                        r = error_result(ST_TRUNC);
                    end
                end
            endcase
        end
        if (emit)
            expected_fields.push_back(r);
    endtask

    task automatic push_byte(input logic [7:0] d, input logic s, input logic e);
        t_frame_byte fb;
        fb.data = d;
        fb.start = s;
        fb.last = e;
        frame_bytes.push_back(fb);
    endtask

    // one random frame: mostly well formed, else truncated, cut by a restart
    // or carrying an overlong id length; sometimes idle noise follows
    task automatic build_frame();
        logic [7:0] body[$];
        int len_at;
        int nb;
        int flavor;
        int sel;
        int idn;
        logic tail_end;
        body.push_back(8'($urandom_range(255)));
        for (int f = 0; f < 2; f++) begin
            sel = $urandom_range(3);
            body.push_back({2'(sel), 6'($urandom_range(63))});
            for (int k = 1; k < (1 << sel); k++)
                body.push_back(8'($urandom_range(255)));
        end
        len_at = body.size();
        idn = $urandom_range(NCID_MAX_ID_BYTES);
        body.push_back(8'(idn));
        for (int k = 0; k < idn + NCID_TOKEN_BYTES; k++)
            body.push_back(8'($urandom_range(255)));
        nb = body.size();
        flavor = $urandom_range(99);
        tail_end = 1'($urandom_range(1));
        if (flavor < 12) begin
            nb = $urandom_range(nb - 2) + 1;
            tail_end = 1'b1;
        end else if (flavor < 20) begin
            nb = $urandom_range(nb - 1, 1);
            tail_end = 1'b0;
        end else if (flavor < 28) begin
            body[len_at] = 8'($urandom_range(255, NCID_MAX_ID_BYTES + 1));
            nb = len_at + 1;
        end
        for (int k = 0; k < nb; k++)
            push_byte(body[k], k == 0, (k == nb - 1) ? tail_end : 1'b0);
        n_frames++;
        n_frame_reqs += nb;
        if ($urandom_range(99) < 15) begin
            repeat ($urandom_range(3, 1))
                push_byte(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)));
        end
    endtask

    // request driver
    always @(posedge clk) begin : driver
        t_frame_byte nxt;
        logic take;
        logic more;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            take = in_valid && o_in_ready;
            more = in_valid && !take;
            if (in_valid && !o_in_ready)
                n_in_stalls++;
            if (take) begin
                parse_frame_byte(cur_byte);
                n_accepted <= n_accepted + 1;
            end
            if (!more) begin
                if (frame_bytes.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    nxt = frame_bytes.pop_front();
                    cur_byte <= nxt;
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off so the parser backs up onto its input
    always @(posedge clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (rst_n && !hold_used && n_total != 0 && n_accepted >= n_total / 6) begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end
    end

    always @(posedge clk) begin
        out_ready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
    end

    // result monitor
    always @(posedge clk) begin : monitor
        t_field_result want;
        if (rst_n && o_out_valid && out_ready) begin
            if (expected_fields.size() == 0) begin
                report_mismatch("unexpected result, kind", 64'(o_field_kind), 64'd0);
            end else begin
                want = expected_fields.pop_front();
                if (o_field_kind != want.kind)
                    report_mismatch("field_kind", 64'(o_field_kind), 64'(want.kind));
                if (o_field_value != want.value)
                    report_mismatch("field_value", 64'(o_field_value), 64'(want.value));
                if (o_byte_index != want.idx)
                    report_mismatch("byte_index", 64'(o_byte_index), 64'(want.idx));
                if (o_parse_status != want.status)
                    report_mismatch("parse_status", 64'(o_parse_status), 64'(want.status));
                if (o_bytes_consumed != want.consumed)
                    report_mismatch("bytes_consumed", 64'(o_bytes_consumed),
                                    64'(want.consumed));
                case (want.status)
                    ST_DONE:  n_done++;
                    ST_TRUNC: n_trunc++;
                    ST_LONG:  n_long++;
                    default: ;
                endcase
                n_checked++;
            end
        end
    end

    always @(posedge clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", n_cycles,
                     expected_fields.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        // idle byte, ignored
        push_byte(8'hFF, 1'b0, 1'b1);
        // truncated on the type byte
        push_byte(8'h00, 1'b1, 1'b1);
        // restart inside an 8-byte varint, then overlong id with buffer end
        push_byte(8'hA5, 1'b1, 1'b0);
        push_byte(8'hC0, 1'b0, 1'b0);
        push_byte(8'h18, 1'b1, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'h3F, 1'b0, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b1);
        // truncated on the byte that completes a 2-byte varint
        push_byte(8'h5A, 1'b1, 1'b0);
        push_byte(8'h40, 1'b0, 1'b0);
        push_byte(8'h01, 1'b0, 1'b1);
        // largest sequence number, zero-length id, buffer end on last token byte
        push_byte(8'h1F, 1'b1, 1'b0);
        repeat (8) push_byte(8'hFF, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        for (int k = 0; k < NCID_TOKEN_BYTES; k++)
            push_byte((k % 2) ? 8'hFF : 8'h00, 1'b0, k == NCID_TOKEN_BYTES - 1);
        n_frames = 5;

        while (n_frame_reqs < RANDOM_BYTES)
            build_frame();
        n_total = frame_bytes.size();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (frame_bytes.size() != 0 || in_valid) @(negedge clk);
        while (expected_fields.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("%0d frames, %0d requests sent, %0d results checked, %0d stalled inputs",
                 n_frames, n_accepted, n_checked, n_in_stalls);
        $display("frames done %0d, truncated %0d, id too long %0d, mismatches %0d",
                 n_done, n_trunc, n_long, n_errors);
        if (n_errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
